// ===== src/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define BARC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("barc assertion failed");

// Next-cycle implication, off while reset is low.
`define BARC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("barc assertion failed");

`endif

// ===== src/barc_pkg.sv =====
`default_nettype none

package barc_pkg;

    localparam int LBA_BITS        = 48;
    localparam int COUNT_BITS      = 16;
    localparam int TOTAL_BITS      = 48;
    localparam int DEPTH_CFG_BITS  = 7;
    localparam int SIZE_BITS       = LBA_BITS + 1;
    localparam int CFG_DATA_BITS   = SIZE_BITS;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int HISTORY_MAX_DEF = 64;

    localparam logic [DEPTH_CFG_BITS-1:0] DEPTH_RESET  = 7'd64;
    localparam logic [SIZE_BITS-1:0]      DEVICE_RESET = {1'b1, {LBA_BITS{1'b0}}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_HISTORY_DEPTH = 2'd0,
        CFG_WINDOW_SIZE   = 2'd1,
        CFG_DEVICE_BLOCKS = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEXT,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic append;
        logic scan_start;
        logic scan_step;
        logic commit;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic ring_full;
        logic scan_last;
        logic pipe_idle;
        logic slot_ready;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== src/barc_if.sv =====
`default_nettype none

interface barc_req_if;
    import barc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LBA_BITS-1:0]   start_lba;
    logic [COUNT_BITS-1:0] block_count;

    modport source (output valid, output start_lba, output block_count, input ready);
    modport sink   (input valid, input start_lba, input block_count, output ready);
endinterface

interface barc_rsp_if;
    import barc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] near_in_request;
    logic [TOTAL_BITS-1:0] near_total;
    logic [TOTAL_BITS-1:0] counted_total;

    modport source (output valid, output near_in_request, output near_total,
                    output counted_total, input ready);
    modport sink   (input valid, input near_in_request, input near_total,
                    input counted_total, output ready);
endinterface

`default_nettype wire

// ===== src/barc_ctrl.sv =====
`default_nettype none

module barc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  barc_pkg::dp_status_t status,
    output barc_pkg::dp_cmd_t    cmd
);
    import barc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (status.cnt_zero)
                begin
                    state_next = ST_FINISH;
                end
                else if (!status.ring_full)
                begin
                    cmd.append = 1'b1;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait for the last distance to reach the minimum and the slot wrap
                if (status.pipe_idle && status.slot_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/barc_dp.sv =====
`default_nettype none

module barc_dp #(
    parameter int HISTORY_MAX = barc_pkg::HISTORY_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  barc_pkg::dp_cmd_t                   cmd,
    output barc_pkg::dp_status_t                status,
    input  logic                                cfg_we,
    input  logic [barc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [barc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic [barc_pkg::LBA_BITS-1:0]       start_lba,
    input  logic [barc_pkg::COUNT_BITS-1:0]     block_count,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [barc_pkg::COUNT_BITS-1:0]     near_in_request,
    output logic [barc_pkg::TOTAL_BITS-1:0]     near_total,
    output logic [barc_pkg::TOTAL_BITS-1:0]     counted_total
);
    import barc_pkg::*;

    localparam int IDX_W = (HISTORY_MAX > 1) ? $clog2(HISTORY_MAX) : 1;
    localparam int CNT_W = $clog2(HISTORY_MAX + 1);
    localparam int DW    = (CNT_W > DEPTH_CFG_BITS) ? CNT_W : DEPTH_CFG_BITS;
    localparam logic [DW-1:0] MAX_WIDE = DW'(HISTORY_MAX);

    // configuration
    logic [DEPTH_CFG_BITS-1:0] depth_cfg_reg;
    logic [SIZE_BITS-1:0]      window_reg;
    logic [SIZE_BITS-1:0]      device_reg;

    // request and ring bookkeeping
    logic [LBA_BITS-1:0]   addr_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] near_here_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic [IDX_W-1:0]      slot_reg;
    logic [CNT_W-1:0]      slot_rem_reg;
    logic [TOTAL_BITS-1:0] near_total_reg;
    logic [TOTAL_BITS-1:0] counted_total_reg;

    // scan pipeline
    logic [IDX_W-1:0]    scan_idx_reg;
    logic [LBA_BITS-1:0] rd_data_reg;
    logic                rd_v_reg;
    logic [LBA_BITS-1:0] dist_reg;
    logic                dist_v_reg;
    logic [LBA_BITS-1:0] best_reg;

    // result register
    logic                  out_valid_reg;
    logic [COUNT_BITS-1:0] near_in_request_reg;
    logic [TOTAL_BITS-1:0] near_total_out_reg;
    logic [TOTAL_BITS-1:0] counted_total_out_reg;

    logic [LBA_BITS-1:0] ring_mem [HISTORY_MAX];

    logic [DW-1:0]       depth_wide;
    logic [CNT_W-1:0]    depth_eff;
    logic [LBA_BITS:0]   diff_fwd;
    logic [LBA_BITS-1:0] dist_next;
    logic                near;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;

    // a depth of zero acts as one, anything above the ring size as the ring size
    assign depth_wide = DW'(depth_cfg_reg);
    always_comb
    begin
        if (depth_cfg_reg == '0)
        begin
            depth_eff = CNT_W'(1);
        end
        else if (depth_wide > MAX_WIDE)
        begin
            depth_eff = CNT_W'(HISTORY_MAX);
        end
        else
        begin
            depth_eff = CNT_W'(depth_wide);
        end
    end

    assign diff_fwd  = {1'b0, addr_reg} - {1'b0, rd_data_reg};
    assign dist_next = diff_fwd[LBA_BITS] ? (rd_data_reg - addr_reg) : diff_fwd[LBA_BITS-1:0];
    assign near      = {1'b0, best_reg} < window_reg;
    assign wr_en     = cmd.append | cmd.commit;
    assign wr_addr   = cmd.append ? fill_reg[IDX_W-1:0] : slot_reg;

    assign status.cnt_zero   = (cnt_reg == '0);
    assign status.ring_full  = (fill_reg >= depth_eff);
    assign status.scan_last  = (CNT_W'(scan_idx_reg) == fill_reg - CNT_W'(1));
    assign status.pipe_idle  = !rd_v_reg && !dist_v_reg;
    assign status.slot_ready = (slot_rem_reg < depth_eff);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign near_in_request = near_in_request_reg;
    assign near_total      = near_total_out_reg;
    assign counted_total   = counted_total_out_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= addr_reg;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= ring_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_cfg_reg     <= DEPTH_RESET;
            window_reg        <= '0;
            device_reg        <= DEVICE_RESET;
            fill_reg          <= '0;
            slot_reg          <= '0;
            near_total_reg    <= '0;
            counted_total_reg <= '0;
            rd_v_reg          <= 1'b0;
            dist_v_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HISTORY_DEPTH: depth_cfg_reg <= cfg_wdata[DEPTH_CFG_BITS-1:0];
                    CFG_WINDOW_SIZE:   window_reg    <= cfg_wdata;
                    CFG_DEVICE_BLOCKS: device_reg    <= cfg_wdata;
                    default:           ;
                endcase
            end
            if (cmd.append)
            begin
                fill_reg <= fill_reg + CNT_W'(1);
                slot_reg <= '0;
            end
            if (cmd.commit)
            begin
                slot_reg <= slot_rem_reg[IDX_W-1:0];
                if (near && near_total_reg != '1)
                begin
                    near_total_reg <= near_total_reg + TOTAL_BITS'(1);
                end
                if (counted_total_reg != '1)
                begin
                    counted_total_reg <= counted_total_reg + TOTAL_BITS'(1);
                end
            end
            rd_v_reg   <= cmd.scan_step;
            dist_v_reg <= rd_v_reg;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg      <= start_lba;
            cnt_reg       <= block_count;
            near_here_reg <= '0;
        end
        else if (cmd.append || cmd.commit)
        begin
            // advance to the next block, address wraps naturally
            addr_reg <= addr_reg + LBA_BITS'(1);
            cnt_reg  <= cnt_reg - COUNT_BITS'(1);
            if (cmd.commit && near)
            begin
                near_here_reg <= near_here_reg + COUNT_BITS'(1);
            end
        end

        if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
            best_reg     <= device_reg[SIZE_BITS-1:1];
            slot_rem_reg <= CNT_W'(slot_reg) + CNT_W'(1);
        end
        else
        begin
            if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            // the best value starts at the clamp, so the clamp needs no compare
            if (dist_v_reg && dist_reg < best_reg)
            begin
                best_reg <= dist_reg;
            end
            // reduce the next slot by repeated subtraction while the scan runs
            if (slot_rem_reg >= depth_eff)
            begin
                slot_rem_reg <= slot_rem_reg - depth_eff;
            end
        end

        dist_reg <= dist_next;

        if (cmd.load_out)
        begin
            near_in_request_reg   <= near_here_reg;
            near_total_out_reg    <= near_total_reg;
            counted_total_out_reg <= counted_total_reg;
        end
    end

endmodule

`default_nettype wire

// ===== src/block_access_randomness_classifier.sv =====
// Block access randomness classifier.
// req channel (valid/ready): one request, start_lba and block_count. Each block
// of it is either appended to the history ring (while the ring holds fewer than
// history_depth addresses) or compared against every held address.
// rsp channel (valid/ready): one item per request with near_in_request and the
// saturating near_total and counted_total.
// cfg port: cfg_we, cfg_index, cfg_wdata; write only while no request is open.
// The scan reads the single ring read port, one entry per cycle. One request is
// handled at a time; req.ready is high only between requests.
// A finished item sits in an output register; a new request is taken while it
// waits. If rsp stalls, the next request finishes its work and then holds.
// Reset sets the fill level, write slot, totals, valid flags and configuration to
// their defaults; the ring contents are not cleared and need no sweep.
`default_nettype none

module block_access_randomness_classifier #(
    parameter int HISTORY_MAX = barc_pkg::HISTORY_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    barc_req_if.sink                            req,
    barc_rsp_if.source                          rsp,
    input  logic                                cfg_we,
    input  logic [barc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [barc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
    import barc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    barc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    barc_dp #(
        .HISTORY_MAX (HISTORY_MAX)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .start_lba       (req.start_lba),
        .block_count     (req.block_count),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .near_in_request (rsp.near_in_request),
        .near_total      (rsp.near_total),
        .counted_total   (rsp.counted_total)
    );

endmodule

`default_nettype wire

// ===== src/barc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module barc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic [barc_pkg::COUNT_BITS-1:0] near_in_request,
    input logic [barc_pkg::TOTAL_BITS-1:0] near_total,
    input logic [barc_pkg::TOTAL_BITS-1:0] counted_total
);
    import barc_pkg::*;

    // a stalled item holds
    `BARC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(near_in_request) && $stable(near_total) && $stable(counted_total))

    // one request at a time: no new item right after one is taken
    `BARC_ASSERT_NEXT(a_one_open, clk, rst_n, req_valid && req_ready, !req_ready)

    // every near block was also counted
    `BARC_ASSERT_IMPLY(a_near_le_counted, clk, rst_n, rsp_valid, near_total <= counted_total)

    // this request's near blocks are part of the running near total
    `BARC_ASSERT_IMPLY(a_req_le_total, clk, rst_n, rsp_valid, TOTAL_BITS'(near_in_request) <= near_total)

endmodule

bind block_access_randomness_classifier barc_checker u_barc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .near_in_request (rsp.near_in_request),
    .near_total      (rsp.near_total),
    .counted_total   (rsp.counted_total)
);

`default_nettype wire
